// ===== src/hcinv_pkg.sv =====
// Shared binary32 types, register indexes and arithmetic functions for the homography block.
package hcinv_pkg;

	typedef logic [31:0] f32_t;

	localparam f32_t F_ONE  = 32'h3F80_0000;
	localparam f32_t F_QNAN = 32'h7FC0_0000;

	// configuration register indexes
	localparam logic [2:0] REG_PAIR_A = 3'd0;
	localparam logic [2:0] REG_PAIR_B = 3'd1;
	localparam logic [2:0] REG_PAIR_C = 3'd2;
	localparam logic [2:0] REG_PAIR_D = 3'd3;
	localparam logic [2:0] REG_LAST   = 3'd4;
	localparam logic [2:0] REG_LIMIT  = 3'd5;
	localparam logic [2:0] REG_TOL    = 3'd6;

	// quotient bits produced by the reciprocal pipeline, one per stage
	localparam int QBITS = 27;
	// exponent handed to the rounder for the raw quotient, before det exponent is taken off
	localparam int RECIP_EXP = 2 * 127 + 50 - QBITS;

	function automatic logic is_nan(f32_t a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(f32_t a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	// Normalize and round to nearest even. Value is m / 2^50 * 2^(e - 127).
	function automatic f32_t fp_round(logic s, logic signed [11:0] e, logic [50:0] m);
		logic [50:0] n;
		logic signed [11:0] ex;
		logic [5:0] lz;
		logic found;
		logic [11:0] sh;
		logic stk;
		logic [23:0] sig;
		logic g;
		logic [31:0] b;
		if (m == 51'd0) return {s, 31'd0};
		lz = 6'd0;
		found = 1'b0;
		for (int i = 50; i >= 0; i--) begin
			if (!found && m[i]) begin
				lz = 6'(50 - i);
				found = 1'b1;
			end
		end
		n = m << lz;
		ex = e - $signed({6'd0, lz});
		if (ex < 12'sd1) begin
			sh = 12'(12'sd1 - ex);
			if (sh >= 12'd51) begin
				stk = |n;
				n = 51'd0;
			end else begin
				stk = |(n & ((51'd1 << sh) - 51'd1));
				n = n >> sh;
			end
			n[0] = n[0] | stk;
			ex = 12'sd1;
		end
		if (ex > 12'sd254) return {s, 8'hFF, 23'd0};
		sig = n[50:27];
		g = n[26];
		stk = |n[25:0];
		// hidden bit carries into the exponent field; denormals keep field zero
		b = {1'b0, 8'(ex - 12'sd1), 23'd0} + {8'd0, sig};
		b = b + {31'd0, g & (stk | sig[0])};
		return {s, b[30:0]};
	endfunction

	function automatic f32_t fp_mul(f32_t a, f32_t b);
		logic s;
		logic a_zero;
		logic b_zero;
		logic [7:0] ea;
		logic [7:0] eb;
		logic [47:0] p;
		s = a[31] ^ b[31];
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		if (is_nan(a) || is_nan(b)) return F_QNAN;
		if ((is_inf(a) && b_zero) || (is_inf(b) && a_zero)) return F_QNAN;
		if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
		if (a_zero || b_zero) return {s, 31'd0};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		p = {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
		return fp_round(s, $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126, {p, 3'd0});
	endfunction

	function automatic f32_t fp_add(f32_t a, f32_t b);
		f32_t x;
		f32_t y;
		logic [7:0] ex;
		logic [7:0] ey;
		logic [7:0] d;
		logic [49:0] mx;
		logic [49:0] my;
		logic [49:0] ms;
		logic [50:0] r;
		if (is_nan(a) || is_nan(b)) return F_QNAN;
		if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return F_QNAN;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (a[30:0] >= b[30:0]) begin
			x = a;
			y = b;
		end else begin
			x = b;
			y = a;
		end
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx = {x[30:23] != 8'd0, x[22:0], 26'd0};
		my = {y[30:23] != 8'd0, y[22:0], 26'd0};
		d = ex - ey;
		if (d >= 8'd50)
			ms = {49'd0, |my};
		else
			ms = (my >> d) | {49'd0, |(my & ((50'd1 << d) - 50'd1))};
		if (x[31] == y[31])
			r = {1'b0, mx} + {1'b0, ms};
		else
			r = {1'b0, mx} - {1'b0, ms};
		if (r == 51'd0) return {x[31] & y[31], 31'd0};
		return fp_round(x[31], $signed({4'd0, ex}) + 12'sd1, r);
	endfunction

	// 0 + x: only a negative zero changes
	function automatic f32_t pos_zero(f32_t a);
		return (a == 32'h8000_0000) ? 32'd0 : a;
	endfunction

	// |a| <= t for non-negative t, false on any NaN
	function automatic logic in_tol(f32_t a, logic [30:0] t);
		return !is_nan(a) && !is_nan({1'b0, t}) && (a[30:0] <= t);
	endfunction

endpackage

// ===== src/hcinv_recip.sv =====
// Pipelined binary32 reciprocal, one quotient bit per stage, with side payload.
module hcinv_recip #(
	parameter int PW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  hcinv_pkg::f32_t    in_det,
	input  logic [PW-1:0]      in_pay,
	output logic               out_valid,
	output hcinv_pkg::f32_t    out_rdet,
	output logic [PW-1:0]      out_pay
);
	import hcinv_pkg::*;

	localparam logic [1:0] K_NORM = 2'd0;
	localparam logic [1:0] K_NAN  = 2'd1;
	localparam logic [1:0] K_INF  = 2'd2;
	localparam logic [1:0] K_ZERO = 2'd3;

	logic                    vld_s  [QBITS+1];
	logic [24:0]             rem_s  [QBITS+1];
	logic [QBITS-1:0]        quo_s  [QBITS+1];
	logic [23:0]             md_s   [QBITS+1];
	logic signed [11:0]      er_s   [QBITS+1];
	logic [1:0]              kind_s [QBITS+1];
	logic                    sgn_s  [QBITS+1];
	logic [PW-1:0]           pay_s  [QBITS+1];

	// operand prep: classify, normalize a denormal divisor
	logic [4:0]         lz;
	logic               found;
	logic [23:0]        md_n;
	logic signed [11:0] er_n;
	logic [1:0]         kind_n;

	always_comb begin
		lz = 5'd0;
		found = 1'b0;
		for (int i = 22; i >= 0; i--) begin
			if (!found && in_det[i]) begin
				lz = 5'(23 - i);
				found = 1'b1;
			end
		end
		if (in_det[30:23] == 8'd0) begin
			md_n = {1'b0, in_det[22:0]} << lz;
			er_n = 12'(RECIP_EXP - 1) + $signed({7'd0, lz});
		end else begin
			md_n = {1'b1, in_det[22:0]};
			er_n = 12'(RECIP_EXP) - $signed({4'd0, in_det[30:23]});
		end
		if (is_nan(in_det))
			kind_n = K_NAN;
		else if (is_inf(in_det))
			kind_n = K_ZERO;
		else if (in_det[30:0] == 31'd0)
			kind_n = K_INF;
		else
			kind_n = K_NORM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= 25'd1 << 23;
			quo_s[0]  <= '0;
			md_s[0]   <= md_n;
			er_s[0]   <= er_n;
			kind_s[0] <= kind_n;
			sgn_s[0]  <= in_det[31];
			pay_s[0]  <= in_pay;
		end
	end

	for (genvar j = 0; j < QBITS; j++) begin : g_bit
		logic        ge;
		logic [24:0] diff;
		assign ge   = rem_s[j] >= {1'b0, md_s[j]};
		assign diff = ge ? (rem_s[j] - {1'b0, md_s[j]}) : rem_s[j];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= {diff[23:0], 1'b0};
				quo_s[j+1]  <= {quo_s[j][QBITS-2:0], ge};
				md_s[j+1]   <= md_s[j];
				er_s[j+1]   <= er_s[j];
				kind_s[j+1] <= kind_s[j];
				sgn_s[j+1]  <= sgn_s[j];
				pay_s[j+1]  <= pay_s[j];
			end
		end
	end

	f32_t rdet_n;

	always_comb begin
		case (kind_s[QBITS])
			K_NAN:   rdet_n = F_QNAN;
			K_INF:   rdet_n = {sgn_s[QBITS], 8'hFF, 23'd0};
			K_ZERO:  rdet_n = {sgn_s[QBITS], 31'd0};
			default: rdet_n = fp_round(sgn_s[QBITS], er_s[QBITS],
				{{(51 - QBITS - 1){1'b0}}, quo_s[QBITS], |rem_s[QBITS]});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rdet <= rdet_n;
			out_pay  <= pay_s[QBITS];
		end
	end

endmodule

// ===== src/homography_invert_compose.sv =====
// Top level: inverts a 3x3 binary32 homography and left-multiplies it by the anchor matrix.
//
// channel   dir  signals                          transfer carries
// s_axis    in   tvalid tready tdata[287:0]       input matrix m00..m22
// m_axis    out  tvalid tready tdata[287:0] tuser composed matrix and two flags
// cfg       in   valid ready index[2:0] data[63:0] one register write
//
// The pipeline has 5 cofactor/determinant stages, 29 in the reciprocal divider,
// which retires one quotient bit per stage, and 5 scale/compose/check stages.
// A new matrix is taken every cycle. The whole pipeline advances together and
// freezes while the output register holds an untaken result; tready drops then.
// Reset clears all valid bits and loads the anchor with identity.
module homography_invert_compose (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [287:0] s_axis_tdata,   // in_m00 .. in_m22, 32 bits each from bit 0
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [287:0] m_axis_tdata,   // out_m00 .. out_m22, 32 bits each from bit 0
	output logic [1:0]   m_axis_tuser,   // singular_fallback, is_identity
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import hcinv_pkg::*;

	localparam int PW = 1 + 9 * 32;

	logic en;

	// configuration
	f32_t        anc_q [9];
	logic [30:0] lim_q;
	logic [30:0] tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++)
				anc_q[k] <= (k == 0 || k == 4 || k == 8) ? F_ONE : 32'd0;
			lim_q <= 31'h2B8C_BCCC;
			tol_q <= 31'h2B8C_BCCC;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PAIR_A: begin
					anc_q[0] <= cfg_data[31:0];
					anc_q[1] <= cfg_data[63:32];
				end
				REG_PAIR_B: begin
					anc_q[2] <= cfg_data[31:0];
					anc_q[3] <= cfg_data[63:32];
				end
				REG_PAIR_C: begin
					anc_q[4] <= cfg_data[31:0];
					anc_q[5] <= cfg_data[63:32];
				end
				REG_PAIR_D: begin
					anc_q[6] <= cfg_data[31:0];
					anc_q[7] <= cfg_data[63:32];
				end
				REG_LAST:  anc_q[8] <= cfg_data[31:0];
				REG_LIMIT: lim_q <= cfg_data[30:0];
				REG_TOL:   tol_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	f32_t m [9];
	always_comb begin
		for (int k = 0; k < 9; k++)
			m[k] = s_axis_tdata[k*32 +: 32];
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic v_s6, v_s7, v_s8, v_s9, v_s10;
	logic rv;

	f32_t pt_s1 [9];
	f32_t pu_s1 [9];
	f32_t m_s1  [3];
	f32_t adj_s2 [9];
	f32_t m_s2  [3];
	f32_t adj_s3 [9];
	f32_t dp_s3 [3];
	f32_t adj_s4 [9];
	f32_t det_s4;
	f32_t dp2_s4;
	f32_t adj_s5 [9];
	f32_t det_s5;
	f32_t inv_s6 [9];
	logic fb_s6, fb_s7, fb_s8, fb_s9;
	f32_t pr_s7 [27];
	f32_t acc_s8 [9];
	f32_t p2_s8 [9];
	f32_t res_s9 [9];
	f32_t out_s10 [9];
	logic fb_s10;
	logic id_s10;

	// cofactor product pairs, adjugate position k takes t - u, odd minors negated
	localparam int TA [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
	localparam int TB [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
	localparam int UA [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
	localparam int UB [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
	localparam logic [8:0] NEG = 9'b010_101_010;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= rv;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// determinant and adjugate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				pt_s1[k] <= fp_mul(m[TA[k]], m[TB[k]]);
				pu_s1[k] <= fp_mul(m[UA[k]], m[UB[k]]);
			end
			for (int k = 0; k < 3; k++)
				m_s1[k] <= m[k];

			for (int k = 0; k < 9; k++)
				adj_s2[k] <= fp_add(pt_s1[k], {~pu_s1[k][31], pu_s1[k][30:0]})
					^ {NEG[k], 31'd0};
			m_s2 <= m_s1;

			adj_s3 <= adj_s2;
			for (int k = 0; k < 3; k++)
				dp_s3[k] <= fp_mul(m_s2[k], adj_s2[3*k]);

			adj_s4 <= adj_s3;
			det_s4 <= fp_add(dp_s3[0], dp_s3[1]);
			dp2_s4 <= dp_s3[2];

			adj_s5 <= adj_s4;
			det_s5 <= fp_add(det_s4, dp2_s4);
		end
	end

	logic          fb_n;
	logic [PW-1:0] pay_in;
	logic [PW-1:0] pay_out;
	f32_t          rdet;

	assign fb_n = !is_nan(det_s5) && !is_nan({1'b0, lim_q}) && (det_s5[30:0] < lim_q);

	always_comb begin
		pay_in[PW-1] = fb_n;
		for (int k = 0; k < 9; k++)
			pay_in[k*32 +: 32] = adj_s5[k];
	end

	hcinv_recip #(.PW(PW)) u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_det    (det_s5),
		.in_pay    (pay_in),
		.out_valid (rv),
		.out_rdet  (rdet),
		.out_pay   (pay_out)
	);

	// scale, compose with the anchor, identity check
	always_ff @(posedge clk) begin
		if (en) begin
			fb_s6 <= pay_out[PW-1];
			for (int k = 0; k < 9; k++) begin
				if (pay_out[PW-1])
					inv_s6[k] <= (k == 0 || k == 4 || k == 8) ? F_ONE : 32'd0;
				else
					inv_s6[k] <= fp_mul(pay_out[k*32 +: 32], rdet);
			end

			fb_s7 <= fb_s6;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					for (int k = 0; k < 3; k++)
						pr_s7[(r*3 + c)*3 + k] <= fp_mul(anc_q[r*3 + k], inv_s6[k*3 + c]);

			fb_s8 <= fb_s7;
			for (int e = 0; e < 9; e++) begin
				acc_s8[e] <= fp_add(pos_zero(pr_s7[e*3]), pr_s7[e*3 + 1]);
				p2_s8[e]  <= pr_s7[e*3 + 2];
			end

			fb_s9 <= fb_s8;
			for (int e = 0; e < 9; e++)
				res_s9[e] <= fp_add(acc_s8[e], p2_s8[e]);
		end
	end

	f32_t diff [9];
	logic id_n;

	always_comb begin
		id_n = 1'b1;
		for (int e = 0; e < 9; e++) begin
			diff[e] = fp_add(res_s9[e], (e == 0 || e == 4 || e == 8) ? 32'hBF80_0000
				: 32'h8000_0000);
			if (!in_tol(diff[e], tol_q))
				id_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 9; e++)
				out_s10[e] <= is_nan(res_s9[e]) ? F_QNAN : res_s9[e];
			fb_s10 <= fb_s9;
			id_s10 <= id_n;
		end
	end

	assign m_axis_tvalid = v_s10;
	assign m_axis_tuser  = {id_s10, fb_s10};
	always_comb begin
		for (int e = 0; e < 9; e++)
			m_axis_tdata[e*32 +: 32] = out_s10[e];
	end

	// pipeline freezes while the output waits
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6,
			v_s7, v_s8, v_s9}))
		else $error("pipeline advanced during output stall");

	// an item in the front stages moves on when the pipeline advances
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s4) |=> v_s5)
		else $error("item lost between determinant stages");

	// an item leaving the divider reaches the scale stage
	a_recip: assert property (@(posedge clk) disable iff (!arst_n)
		(en && rv) |=> v_s6)
		else $error("item lost after reciprocal");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the homography inverse-and-compose block.
module tb;
	import hcinv_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 50;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam f32_t F_ZERO = 32'h0000_0000;
	localparam f32_t F_TOL_CENTI = 32'h3C23_D70A;  // 0.01
	localparam f32_t F_LIMIT_RST = 32'h2B8C_BCCC;

	typedef struct packed {
		logic         ident;
		logic         fallback;
		logic [287:0] mat;
	} composed_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [287:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [287:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;

	f32_t        anchor[9];
	logic [30:0] limit_q;
	logic [30:0] tol_q;

	composed_t pending[$];
	int  mismatches = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	int  hold_cycles = 0;
	bit  gaps_on = 1'b1;
	bit  stalls_on = 1'b1;

	homography_invert_compose dut (.*);

	always #5 clk = ~clk;

	// ---------------- binary32 arithmetic, round to nearest even ----------------

	function automatic bit f_nan(f32_t a);
		return a[30:23] == 8'hFF && a[22:0] != 0;
	endfunction

	function automatic bit f_inf(f32_t a);
		return a[30:23] == 8'hFF && a[22:0] == 0;
	endfunction

	function automatic bit f_zero(f32_t a);
		return a[30:0] == 0;
	endfunction

	// value = m * 2^e
	function automatic void split(input f32_t a, output logic [63:0] m, output int e);
		if (a[30:23] == 0) begin
			m = {41'd0, a[22:0]};
			e = -149;
		end else begin
			m = {40'd0, 1'b1, a[22:0]};
			e = int'(a[30:23]) - 150;
		end
	endfunction

	// round sign * m * 2^e to binary32, m nonzero
	function automatic f32_t round_f32(logic s, int e, logic [63:0] m);
		int p;
		int sh;
		logic [63:0] q;
		logic [127:0] x;
		logic g;
		logic st;
		longint b;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (m[i]) p = i;
		sh = p - 23;
		if (sh < -149 - e) sh = -149 - e;
		if (sh <= 0) begin
			q = m << (-sh);
			g = 1'b0;
			st = 1'b0;
		end else if (sh > 64) begin
			q = 0;
			g = 1'b0;
			st = 1'b1;
		end else begin
			x = {m, 64'd0} >> sh;
			q = x[127:64];
			g = x[63];
			st = |x[62:0];
		end
		if (g && (st || q[0])) q = q + 1;
		if (q == 0) return {s, 31'd0};
		// hidden bit carries into the exponent field
		b = (longint'(sh + e + 149) << 23) + longint'(q);
		if (b >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
		return {s, b[30:0]};
	endfunction

	function automatic f32_t f_mul(f32_t a, f32_t b);
		logic s;
		logic [63:0] ma, mb;
		int ea, eb;
		s = a[31] ^ b[31];
		if (f_nan(a) || f_nan(b)) return F_QNAN;
		if ((f_inf(a) && f_zero(b)) || (f_inf(b) && f_zero(a))) return F_QNAN;
		if (f_inf(a) || f_inf(b)) return {s, 8'hFF, 23'd0};
		if (f_zero(a) || f_zero(b)) return {s, 31'd0};
		split(a, ma, ea);
		split(b, mb, eb);
		return round_f32(s, ea + eb, ma * mb);
	endfunction

	function automatic f32_t f_add(f32_t a, f32_t b);
		f32_t t;
		logic [63:0] ma, mb, wx, wy, sum;
		int ea, eb, d;
		logic s;
		if (f_nan(a) || f_nan(b)) return F_QNAN;
		if (f_inf(a) && f_inf(b) && a[31] != b[31]) return F_QNAN;
		if (f_inf(a)) return a;
		if (f_inf(b)) return b;
		if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
		if (f_zero(a)) return b;
		if (f_zero(b)) return a;
		split(a, ma, ea);
		split(b, mb, eb);
		if (eb > ea) begin
			t = a; a = b; b = t;
			split(a, ma, ea);
			split(b, mb, eb);
		end
		d = ea - eb;
		// 38 guard bits below the larger operand, sticky in the lsb
		wx = ma << 38;
		if (d <= 38)
			wy = mb << (38 - d);
		else if (d - 38 >= 64)
			wy = 64'd1;
		else
			wy = (mb >> (d - 38)) | {63'd0, |(mb & ((64'd1 << (d - 38)) - 1))};
		if (a[31] == b[31]) begin
			sum = wx + wy;
			s = a[31];
		end else if (wx >= wy) begin
			sum = wx - wy;
			s = a[31];
		end else begin
			sum = wy - wx;
			s = b[31];
		end
		if (sum == 0) return F_ZERO;
		return round_f32(s, ea - 38, sum);
	endfunction

	function automatic f32_t f_recip(f32_t a);
		logic [63:0] m, num, q, r;
		int e;
		if (f_nan(a)) return F_QNAN;
		if (f_inf(a)) return {a[31], 31'd0};
		if (f_zero(a)) return {a[31], 8'hFF, 23'd0};
		split(a, m, e);
		num = 64'd1 << 62;
		q = num / m;
		r = num % m;
		q = (q << 1) | {63'd0, r != 0};
		return round_f32(a[31], -63 - e, q);
	endfunction

	function automatic f32_t f_neg(f32_t a);
		return {~a[31], a[30:0]};
	endfunction

	// p*q - r*s
	function automatic f32_t minor2(f32_t p, f32_t q, f32_t r, f32_t s);
		return f_add(f_mul(p, q), f_neg(f_mul(r, s)));
	endfunction

	function automatic composed_t compose_expected(logic [287:0] d);
		f32_t m[9], inv[9], res[9];
		f32_t det, rdet, acc, diff;
		composed_t c;
		for (int k = 0; k < 9; k++) m[k] = d[32*k +: 32];
		inv[0] = minor2(m[4], m[8], m[5], m[7]);
		inv[3] = f_neg(minor2(m[3], m[8], m[5], m[6]));
		inv[6] = minor2(m[3], m[7], m[4], m[6]);
		inv[1] = f_neg(minor2(m[1], m[8], m[2], m[7]));
		inv[4] = minor2(m[0], m[8], m[2], m[6]);
		inv[7] = f_neg(minor2(m[0], m[7], m[1], m[6]));
		inv[2] = minor2(m[1], m[5], m[2], m[4]);
		inv[5] = f_neg(minor2(m[0], m[5], m[2], m[3]));
		inv[8] = minor2(m[0], m[4], m[1], m[3]);
		det = f_add(f_add(f_mul(m[0], inv[0]), f_mul(m[1], inv[3])), f_mul(m[2], inv[6]));
		c.fallback = !f_nan(det) && !f_nan({1'b0, limit_q}) && det[30:0] < limit_q;
		if (c.fallback) begin
			for (int k = 0; k < 9; k++) inv[k] = (k % 4 == 0) ? F_ONE : F_ZERO;
		end else begin
			rdet = f_recip(det);
			for (int k = 0; k < 9; k++) inv[k] = f_mul(inv[k], rdet);
		end
		c.ident = 1'b1;
		for (int r = 0; r < 3; r++)
			for (int col = 0; col < 3; col++) begin
				acc = F_ZERO;
				for (int k = 0; k < 3; k++)
					acc = f_add(acc, f_mul(anchor[r*3+k], inv[k*3+col]));
				res[r*3+col] = acc;
			end
		for (int k = 0; k < 9; k++) begin
			diff = f_add(res[k], f_neg((k % 4 == 0) ? F_ONE : F_ZERO));
			if (f_nan(diff) || f_nan({1'b0, tol_q}) || diff[30:0] > tol_q) c.ident = 1'b0;
			c.mat[32*k +: 32] = f_nan(res[k]) ? F_QNAN : res[k];
		end
		return c;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [63:0] v);
		case (idx)
			REG_PAIR_A: begin anchor[0] = v[31:0]; anchor[1] = v[63:32]; end
			REG_PAIR_B: begin anchor[2] = v[31:0]; anchor[3] = v[63:32]; end
			REG_PAIR_C: begin anchor[4] = v[31:0]; anchor[5] = v[63:32]; end
			REG_PAIR_D: begin anchor[6] = v[31:0]; anchor[7] = v[63:32]; end
			REG_LAST:   anchor[8] = v[31:0];
			REG_LIMIT:  limit_q = v[30:0];
			REG_TOL:    tol_q = v[30:0];
			default: ;
		endcase
	endfunction

	// ---------------- monitors ----------------

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			pending.push_back(compose_expected(s_axis_tdata));
	end

	always @(posedge clk) begin
		composed_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			stall_left = stalls_on ? $urandom_range(0, 19) : 0;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer");
			end else begin
				want = pending.pop_front();
				for (int k = 0; k < 9; k++)
					if (m_axis_tdata[32*k +: 32] !== want.mat[32*k +: 32]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("entry %0d: expected %h got %h", k,
								want.mat[32*k +: 32], m_axis_tdata[32*k +: 32]);
					end
				if (m_axis_tuser[0] !== want.fallback) begin
					mismatches++;
					if (mismatches <= 10)
						$display("singular_fallback: expected %b got %b",
							want.fallback, m_axis_tuser[0]);
				end
				if (m_axis_tuser[1] !== want.ident) begin
					mismatches++;
					if (mismatches <= 10)
						$display("is_identity: expected %b got %b", want.ident, m_axis_tuser[1]);
				end
			end
		end
	end

	// receiver: per-result stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles--;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[homography_invert_compose] ERROR");
				$finish;
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	task automatic send_matrix(input logic [287:0] d);
		int gap;
		gap = gaps_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic stream_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		stream_idle();
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic f32_t moderate();
		return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
	endfunction

	function automatic f32_t any_value();
		f32_t odd[10] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
			32'h7F7F_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h3F80_0000, 32'hBF80_0000};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return moderate();
			6, 7: return $urandom;
			8: return odd[$urandom_range(0, 9)];
			default: return {1'($urandom), 8'd0, 23'($urandom)};
		endcase
	endfunction

	function automatic logic [287:0] random_matrix(int near_anchor_pct);
		logic [287:0] d;
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		for (int i = 0; i < 9; i++) d[32*i +: 32] = moderate();
		if (pick < near_anchor_pct) begin
			// the anchor itself, perturbed in a few low bits: result lands near identity
			for (int i = 0; i < 9; i++) d[32*i +: 32] = anchor[i];
			k = $urandom_range(0, 8);
			d[32*k +: 2] = d[32*k +: 2] ^ 2'($urandom);
		end else if (pick < near_anchor_pct + 10) begin
			k = $urandom_range(0, 2);
			d[32*((k+1)%3) +: 32] = d[32*k +: 32];
			d[32*(3+(k+1)%3) +: 32] = d[32*(3+k) +: 32];
			d[32*(6+(k+1)%3) +: 32] = d[32*(6+k) +: 32];
		end else if (pick < near_anchor_pct + 25) begin
			for (int i = 0; i < 9; i++) d[32*i +: 32] = any_value();
		end
		return d;
	endfunction

	task automatic random_items(int count, int near_anchor_pct);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				gaps_on = $urandom_range(0, 2) != 0;
				stalls_on = $urandom_range(0, 2) != 0;
			end
			send_matrix(random_matrix(near_anchor_pct));
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		drain();
	endtask

	function automatic logic [287:0] diag(f32_t a, f32_t b, f32_t c);
		return {c, F_ZERO, F_ZERO, F_ZERO, b, F_ZERO, F_ZERO, F_ZERO, a};
	endfunction

	// ---------------- tests ----------------

	task automatic test_directed();
		send_matrix(diag(F_ONE, F_ONE, F_ONE));
		send_matrix('0);
		send_matrix({288{1'b1}});
		send_matrix(diag(32'h7FC0_0000, F_ONE, F_ONE));
		send_matrix(diag(32'h7F80_0000, F_ONE, F_ONE));
		send_matrix(diag(32'h7F7F_FFFF, 32'h7F7F_FFFF, F_ONE));
		send_matrix(diag(32'hBF80_0000, 32'hC000_0000, 32'h4040_0000));
		send_matrix(diag(32'h0000_0001, F_ONE, F_ONE));
		send_matrix(diag(32'h3580_0000, 32'h3580_0000, F_ONE));  // det 2^-40, below limit
		send_matrix(diag(32'h3600_0000, 32'h3600_0000, F_ONE));  // det 2^-38, above limit
		send_matrix({9{F_ONE}});
		send_matrix({9{32'h8000_0000}});
		send_matrix({32'h3F80_0000, 32'h0, 32'h0, 32'h4120_0000, 32'h3F80_0000,
			32'h0, 32'hC2C8_0000, 32'h4348_0000, 32'h3F80_0000});
		send_matrix({9{32'h007F_FFFF}});
		drain();
	endtask

	task automatic test_anchor_and_tolerance();
		write_reg(REG_PAIR_A, {moderate(), moderate()});
		write_reg(REG_PAIR_B, {moderate(), moderate()});
		write_reg(REG_PAIR_C, {moderate(), moderate()});
		write_reg(REG_PAIR_D, {moderate(), moderate()});
		write_reg(REG_LAST, {32'd0, moderate()});
		write_reg(REG_LIMIT, 64'd0);
		write_reg(REG_TOL, {32'd0, F_TOL_CENTI});
		send_matrix('0);
		send_matrix(diag(32'h0000_0001, F_ONE, F_ONE));
		random_items(500, 20);
	endtask

	task automatic test_extreme_registers();
		write_reg(REG_PAIR_A, '1);
		write_reg(REG_PAIR_B, '0);
		write_reg(REG_LIMIT, '1);   // NaN limit: never falls back
		write_reg(REG_TOL, {32'd0, 32'h7F80_0000});
		random_items(150, 10);
		write_reg(REG_PAIR_A, {2{32'h7F7F_FFFF}});
		write_reg(REG_PAIR_B, {2{32'hFF7F_FFFF}});
		write_reg(REG_PAIR_C, {2{32'h0000_0001}});
		write_reg(REG_PAIR_D, '0);
		write_reg(REG_LAST, '1);
		write_reg(REG_LIMIT, {32'd0, 32'h7F80_0000});  // infinite limit: finite det falls back
		write_reg(REG_TOL, {32'd0, 32'h7FFF_FFFF});
		write_reg(REG_UNUSED, '1);
		random_items(150, 10);
	endtask

	task automatic test_backpressure();
		write_reg(REG_PAIR_A, {F_ZERO, F_ONE});
		write_reg(REG_PAIR_B, '0);
		write_reg(REG_PAIR_C, {F_ZERO, F_ONE});
		write_reg(REG_PAIR_D, '0);
		write_reg(REG_LAST, {32'd0, F_ONE});
		write_reg(REG_LIMIT, {32'd0, F_LIMIT_RST});
		write_reg(REG_TOL, {32'd0, F_TOL_CENTI});
		gaps_on = 1'b0;
		hold_cycles = 300;
		for (int i = 0; i < 120; i++) send_matrix(random_matrix(30));
		gaps_on = 1'b1;
		drain();
	endtask

	initial begin
		for (int k = 0; k < 9; k++) anchor[k] = (k % 4 == 0) ? F_ONE : F_ZERO;
		limit_q = F_LIMIT_RST[30:0];
		tol_q = F_LIMIT_RST[30:0];
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		random_items(500, 5);
		test_anchor_and_tolerance();
		test_extreme_registers();
		test_backpressure();
		random_items(500, 40);
		if (mismatches == 0)
			$display("[homography_invert_compose] OK");
		else
			$display("[homography_invert_compose] ERROR");
		$finish;
	end

endmodule
